[hw/rtl/kvt_pkg.sv]
// Shared constants, codes and word types of the key-value table.
package kvt_pkg;

  localparam int unsigned KvtTableDepth = 16;
  localparam int unsigned KvtKeyBits    = 16;
  localparam int unsigned KvtValueBits  = 8;
  localparam int unsigned KvtCountBits  = 5;

  typedef enum logic [1:0] {
    FuncPut   = 2'd0,
    FuncFind  = 2'd1,
    FuncErase = 2'd2
  } kvt_func_e;

  typedef enum logic [1:0] {
    StatusHit  = 2'd0,
    StatusDone = 2'd1,
    StatusMiss = 2'd2,
    StatusFull = 2'd3
  } kvt_status_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StScan,
    StWrite,
    StResp
  } kvt_state_e;

  typedef struct packed {
    logic [1:0]              func;
    logic [KvtKeyBits-1:0]   key;
    logic [KvtValueBits-1:0] value;
  } kvt_req_t;

  typedef struct packed {
    logic                    found;
    logic [KvtValueBits-1:0] read_value;
    kvt_status_e             status;
    logic [KvtCountBits-1:0] entry_count;
  } kvt_resp_t;

  typedef struct packed {
    logic                    valid;
    logic [KvtKeyBits-1:0]   key;
    logic [KvtValueBits-1:0] value;
  } kvt_entry_t;

endpackage

[hw/rtl/key_value_table_top.sv]
// Top level of the key-value table: sequencer, entry memory and output register.
// A fixed-capacity table of TableDepth entries that maps a key to a value. Each request word
// (put, find or erase) sweeps the entry memory through its single read port, one entry per
// cycle, then writes back the entry that a put or a hit erase changes. A new request is not
// taken until the result of the last one has left the sequencer. The result word waits in an
// output register, so a stalled result does not hold back the next request. After reset a
// clearing pass marks every entry free; in_stall_o stays high during that pass.
module key_value_table_top import kvt_pkg::*; #(
  parameter int unsigned TableDepth = KvtTableDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  kvt_req_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output kvt_resp_t out_word_o
);

  localparam int unsigned IdxBits = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  logic res_valid;
  logic res_ready;
  kvt_resp_t res_word;
  logic mem_we;
  logic [IdxBits-1:0] mem_waddr;
  kvt_entry_t mem_wdata;
  logic mem_re;
  logic [IdxBits-1:0] mem_raddr;
  kvt_entry_t mem_rdata;
  logic out_valid_q, out_valid_d;
  kvt_resp_t out_word_q, out_word_d;

  kvt_ctrl #(
    .Depth   (TableDepth),
    .IdxBits (IdxBits)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_word_o  (res_word),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  kvt_mem #(
    .Depth   (TableDepth),
    .IdxBits (IdxBits)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_word_d  = res_word;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Request accepted while the previous one is still in the sweep.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (TableDepth >= 32) || (out_word_o.entry_count <= TableDepth))
    else $error("Entry count exceeds the table depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.read_value != '0) |->
      out_word_o.found && (out_word_o.status == StatusHit))
    else $error("Read value is nonzero without a hit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_word_o.status == StatusFull) || (out_word_o.status == StatusMiss)) |->
      !out_word_o.found)
    else $error("Found is set on a full or not-found result.");

endmodule

[hw/rtl/kvt_mem.sv]
// Entry memory of the key-value table: one write port, one registered read port.
module kvt_mem import kvt_pkg::*; #(
  parameter int unsigned Depth   = KvtTableDepth,
  parameter int unsigned IdxBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [IdxBits-1:0] waddr_i,
  input  kvt_entry_t         wdata_i,
  input  logic               re_i,
  input  logic [IdxBits-1:0] raddr_i,
  output kvt_entry_t         rdata_o
);

  kvt_entry_t mem_q [Depth];
  kvt_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/kvt_ctrl.sv]
// Sequencer of the key-value table: clearing pass, entry sweep, write-back and result.
module kvt_ctrl import kvt_pkg::*; #(
  parameter int unsigned Depth   = KvtTableDepth,
  parameter int unsigned IdxBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kvt_req_t           in_word_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output kvt_resp_t          res_word_o,
  output logic               mem_we_o,
  output logic [IdxBits-1:0] mem_waddr_o,
  output kvt_entry_t         mem_wdata_o,
  output logic               mem_re_o,
  output logic [IdxBits-1:0] mem_raddr_o,
  input  kvt_entry_t         mem_rdata_i
);

  localparam int unsigned CntBits = $clog2(Depth + 1);
  localparam int unsigned ExtBits = (CntBits > KvtCountBits) ? CntBits : KvtCountBits;

  kvt_state_e state_q, state_d;
  kvt_req_t req_q, req_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [CntBits-1:0] occ_q, occ_d;
  logic hit_q, hit_d;
  logic [IdxBits-1:0] hit_idx_q, hit_idx_d;
  logic [KvtValueBits-1:0] hit_val_q, hit_val_d;
  logic free_q, free_d;
  logic [IdxBits-1:0] free_idx_q, free_idx_d;
  kvt_resp_t res_q, res_d;
  logic [IdxBits-1:0] cmp_idx;
  logic [ExtBits-1:0] occ_ext;

  assign cmp_idx = cnt_q[IdxBits-1:0] - 1'b1;
  assign occ_ext = ExtBits'(occ_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      cnt_q   <= '0;
      occ_q   <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      occ_q   <= occ_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    hit_idx_q  <= hit_idx_d;
    hit_val_q  <= hit_val_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    occ_d       = occ_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_val_d   = hit_val_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    res_d       = res_q;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q[IdxBits-1:0];
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = cnt_q[IdxBits-1:0];

    case (state_q)
      StClear: begin
        mem_we_o = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CntBits'(Depth - 1)) begin
          cnt_d   = '0;
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req_d   = in_word_i;
          cnt_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          state_d = StScan;
        end
      end
      StScan: begin
        mem_re_o = (cnt_q != CntBits'(Depth));
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          if (mem_rdata_i.valid && (mem_rdata_i.key == req_q.key) && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx;
            hit_val_d = mem_rdata_i.value;
          end
          if (!mem_rdata_i.valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx;
          end
        end
        if (cnt_q == CntBits'(Depth)) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        res_d.found      = 1'b0;
        res_d.read_value = '0;
        res_d.status     = StatusMiss;
        mem_waddr_o      = hit_idx_q;
        mem_wdata_o      = '{valid: 1'b1, key: req_q.key, value: req_q.value};
        case (req_q.func)
          FuncPut: begin
            if (hit_q) begin
              mem_we_o     = 1'b1;
              res_d.found  = 1'b1;
              res_d.status = StatusHit;
            end else if (free_q) begin
              mem_we_o     = 1'b1;
              mem_waddr_o  = free_idx_q;
              occ_d        = occ_q + 1'b1;
              res_d.status = StatusDone;
            end else begin
              res_d.status = StatusFull;
            end
          end
          FuncFind: begin
            if (hit_q) begin
              res_d.found      = 1'b1;
              res_d.read_value = hit_val_q;
              res_d.status     = StatusHit;
            end
          end
          FuncErase: begin
            if (hit_q) begin
              mem_we_o          = 1'b1;
              mem_wdata_o.valid = 1'b0;
              occ_d             = occ_q - 1'b1;
              res_d.found       = 1'b1;
              res_d.status      = StatusDone;
            end
          end
          default: begin
          end
        endcase
        res_d.entry_count = occ_ext[KvtCountBits-1:0];
        state_d           = StResp;
      end
      StResp: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign res_word_o = res_q;

endmodule
